/* rtl/mse_pkg.sv */
// Shared types and constants for the MIPS subset execute unit.
`default_nettype none
package mse_pkg;

    localparam int WORD_W    = 32;
    localparam int IDX_W     = 5;
    localparam int REG_COUNT = 32;
    localparam int MADDR_W   = 9;
    localparam logic [IDX_W-1:0] LINK_REG = 5'd31;

    typedef enum logic [4:0] {
        OP_ADD    = 5'd0,
        OP_ADDI   = 5'd1,
        OP_SUB    = 5'd2,
        OP_SLT    = 5'd3,
        OP_MULT   = 5'd4,
        OP_DIV    = 5'd5,
        OP_MFHI   = 5'd6,
        OP_MFLO   = 5'd7,
        OP_SRL    = 5'd8,
        OP_SLL    = 5'd9,
        OP_AND    = 5'd10,
        OP_OR     = 5'd11,
        OP_XOR    = 5'd12,
        OP_JR     = 5'd13,
        OP_LW     = 5'd14,
        OP_SW     = 5'd15,
        OP_LUI    = 5'd16,
        OP_BEQ    = 5'd17,
        OP_BNE    = 5'd18,
        OP_BGTZ   = 5'd19,
        OP_BLEZ   = 5'd20,
        OP_J      = 5'd21,
        OP_JAL    = 5'd22,
        OP_SETREG = 5'd23
    } opcode_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic div_start;
        logic commit;
        logic clr_step;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_div;
        logic div_done;
        logic clr_last;
        logic out_free;
    } ctrl_sts_t;

endpackage
`default_nettype wire

/* rtl/mse_ram.sv */
// Generic RAM: one write port, one registered read port.
`default_nettype none
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/mse_div.sv */
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module mse_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mse_pkg::WORD_W-1:0] dividend,
    input  logic [mse_pkg::WORD_W-1:0] divisor,
    output logic                       done,
    output logic [mse_pkg::WORD_W-1:0] quotient,
    output logic [mse_pkg::WORD_W-1:0] remainder
);
    import mse_pkg::*;

    localparam int CW = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // borrow clear: subtract fits
            if (!trial[WORD_W])
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

/* rtl/mse_dp.sv */
// Datapath: register file, data RAM, pc/hi/lo, divider and result register.
`default_nettype none
module mse_dp #(
    parameter int MEM_WORDS = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mse_pkg::ctrl_cmd_t                 cmd,
    output mse_pkg::ctrl_sts_t                 sts,
    input  logic [4:0]                         command,
    input  logic [mse_pkg::IDX_W-1:0]          dest_index,
    input  logic [mse_pkg::IDX_W-1:0]          src_a_index,
    input  logic [mse_pkg::IDX_W-1:0]          src_b_index,
    input  logic signed [mse_pkg::WORD_W-1:0]  immediate,
    input  logic [mse_pkg::IDX_W-1:0]          shift_amount,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mse_pkg::WORD_W-1:0]         next_pc,
    output logic                               reg_written,
    output logic [mse_pkg::IDX_W-1:0]          written_index,
    output logic signed [mse_pkg::WORD_W-1:0]  written_value,
    output logic signed [mse_pkg::WORD_W-1:0]  hi_value,
    output logic signed [mse_pkg::WORD_W-1:0]  lo_value,
    output logic                               mem_written,
    output logic [mse_pkg::MADDR_W-1:0]        mem_address,
    output logic                               divide_by_zero,
    output logic signed [mse_pkg::WORD_W-1:0]  probe_value
);
    import mse_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [WORD_W-1:0] ADDR_DIV   = WORD_W'(MEM_WORDS);
    // floor(2^32 / MEM_WORDS): the quotient estimate is exact or one low
    localparam logic [WORD_W-1:0] ADDR_RECIP = WORD_W'((64'd1 << WORD_W) / 64'(MEM_WORDS));

    // captured instruction
    logic [4:0]        op_reg;
    logic [IDX_W-1:0]  rd_reg, rb_reg;
    logic [WORD_W-1:0] imm_reg;
    logic [IDX_W-1:0]  sh_reg;
    logic              a_vld_reg, b_vld_reg;
    // operands
    logic [WORD_W-1:0] a_reg, b_reg;
    logic [2*WORD_W-1:0] prod_reg;
    // architectural state
    logic [WORD_W-1:0] pc_reg, pc_next;
    logic [WORD_W-1:0] hi_reg, hi_next;
    logic [WORD_W-1:0] lo_reg, lo_next;
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [AW-1:0]     clr_reg;
    logic              out_valid_reg;
    // address reduction pipeline
    logic [WORD_W-1:0] ea_reg, qe_reg, rraw_reg, arem_reg;
    logic [3:0]        ag_pipe_reg;
    // result register
    logic [WORD_W-1:0] npc_out_reg, wval_out_reg, hi_out_reg, lo_out_reg, probe_out_reg;
    logic              wr_out_reg, mw_out_reg, dz_out_reg;
    logic [IDX_W-1:0]  widx_out_reg;
    logic [MADDR_W-1:0] maddr_out_reg;

    logic [WORD_W-1:0] rf_rd_a, rf_rd_b, a_cur, b_cur, mem_rd;
    logic signed [2*WORD_W-1:0] prod_c;
    logic [WORD_W-1:0] div_dividend, div_divisor, div_quo, div_rem;
    logic              div_done;
    logic              is_div, div_go, ag_start;
    logic [2*WORD_W-1:0] ea_prod;
    logic [WORD_W-1:0] q_times_d;

    logic              wr;
    logic [IDX_W-1:0]  widx;
    logic [WORD_W-1:0] wval;
    logic              mw, dz;
    logic [MADDR_W-1:0] maddr;
    logic [WORD_W-1:0] branch_pc;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // register file: two copies, one per read port
    mse_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
        .clk     (clk),
        .wr_en   (cmd.commit && wr),
        .wr_addr (widx),
        .wr_data (wval),
        .rd_addr (src_a_index),
        .rd_data (rf_rd_a)
    );

    mse_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
        .clk     (clk),
        .wr_en   (cmd.commit && wr),
        .wr_addr (widx),
        .wr_data (wval),
        .rd_addr (src_b_index),
        .rd_data (rf_rd_b)
    );

    mse_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_dmem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (arem_reg[AW-1:0]),
        .rd_data (mem_rd)
    );

    // never-written registers read as zero
    assign a_cur  = a_vld_reg ? rf_rd_a : '0;
    assign b_cur  = b_vld_reg ? rf_rd_b : '0;
    assign prod_c = $signed(a_cur) * $signed(b_cur);

    assign is_div   = (opcode_t'(op_reg) == OP_DIV);
    assign div_go   = cmd.div_start && is_div;
    assign ag_start = cmd.div_start && !is_div;

    // div runs on magnitudes
    assign div_dividend = a_cur[WORD_W-1] ? -a_cur : a_cur;
    assign div_divisor  = b_cur[WORD_W-1] ? -b_cur : b_cur;

    mse_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_go),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // lw/sw address mod MEM_WORDS: reciprocal estimate, multiply-subtract, one fixup
    assign ea_prod   = 64'(ea_reg) * 64'(ADDR_RECIP);
    assign q_times_d = qe_reg * ADDR_DIV;

    assign branch_pc = pc_reg + imm_reg;

    always_comb
    begin
        wr      = 1'b0;
        widx    = '0;
        wval    = '0;
        mw      = 1'b0;
        dz      = 1'b0;
        maddr   = '0;
        pc_next = pc_reg + 1'b1;
        hi_next = hi_reg;
        lo_next = lo_reg;
        unique case (opcode_t'(op_reg))
            OP_ADD:  begin wr = 1'b1; widx = rd_reg; wval = a_reg + b_reg; end
            OP_ADDI: begin wr = 1'b1; widx = rd_reg; wval = a_reg + imm_reg; end
            OP_SUB:  begin wr = 1'b1; widx = rd_reg; wval = a_reg - b_reg; end
            OP_SLT:
            begin
                wr = 1'b1; widx = rd_reg;
                wval = {{(WORD_W-1){1'b0}}, ($signed(a_reg) < $signed(b_reg))};
            end
            OP_MULT:
            begin
                hi_next = prod_reg[2*WORD_W-1:WORD_W];
                lo_next = prod_reg[WORD_W-1:0];
            end
            OP_DIV:
            begin
                if (b_reg == '0)
                begin
                    dz = 1'b1;
                end
                else
                begin
                    lo_next = (a_reg[WORD_W-1] ^ b_reg[WORD_W-1]) ? -div_quo : div_quo;
                    hi_next = a_reg[WORD_W-1] ? -div_rem : div_rem;
                end
            end
            OP_MFHI: begin wr = 1'b1; widx = rd_reg; wval = hi_reg; end
            OP_MFLO: begin wr = 1'b1; widx = rd_reg; wval = lo_reg; end
            OP_SRL:  begin wr = 1'b1; widx = rd_reg; wval = b_reg >> sh_reg; end
            OP_SLL:  begin wr = 1'b1; widx = rd_reg; wval = b_reg << sh_reg; end
            OP_AND:  begin wr = 1'b1; widx = rd_reg; wval = a_reg & b_reg; end
            OP_OR:   begin wr = 1'b1; widx = rd_reg; wval = a_reg | b_reg; end
            OP_XOR:  begin wr = 1'b1; widx = rd_reg; wval = a_reg ^ b_reg; end
            OP_JR:   pc_next = a_reg;
            OP_LW:
            begin
                maddr = arem_reg[MADDR_W-1:0];
                wr = 1'b1; widx = rb_reg; wval = mem_rd;
            end
            OP_SW:
            begin
                maddr = arem_reg[MADDR_W-1:0];
                mw = 1'b1;
            end
            OP_LUI:  begin wr = 1'b1; widx = rd_reg; wval = {imm_reg[15:0], 16'h0000}; end
            OP_BEQ:  if (a_reg == b_reg) pc_next = branch_pc;
            OP_BNE:  if (a_reg != b_reg) pc_next = branch_pc;
            OP_BGTZ: if ($signed(a_reg) > 0) pc_next = branch_pc;
            OP_BLEZ: if ($signed(a_reg) <= 0) pc_next = branch_pc;
            OP_J:    pc_next = branch_pc;
            OP_JAL:
            begin
                wr = 1'b1; widx = LINK_REG; wval = pc_reg + 1'b1;
                pc_next = branch_pc;
            end
            OP_SETREG:
            begin
                wr = 1'b1; widx = rd_reg; wval = imm_reg;
                pc_next = pc_reg;
            end
            default: ;
        endcase
    end

    assign mem_we    = cmd.clr_step || (cmd.commit && mw);
    assign mem_waddr = cmd.clr_step ? clr_reg : arem_reg[AW-1:0];
    assign mem_wdata = cmd.clr_step ? '0 : b_reg;

    // needs_div / div_done cover both the divider and the address pipeline
    assign sts = '{
        needs_div: (opcode_t'(op_reg) inside {OP_DIV, OP_LW, OP_SW}),
        div_done:  div_done || ag_pipe_reg[3],
        clr_last:  (clr_reg == AW'(MEM_WORDS - 1)),
        out_free:  !out_valid_reg || !out_stall
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            rf_valid_reg  <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            ag_pipe_reg   <= '0;
        end
        else
        begin
            ag_pipe_reg <= {ag_pipe_reg[2:0], ag_start};
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                pc_reg <= pc_next;
                hi_reg <= hi_next;
                lo_reg <= lo_next;
                if (wr)
                begin
                    rf_valid_reg[widx] <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= command;
            rd_reg    <= dest_index;
            rb_reg    <= src_b_index;
            imm_reg   <= immediate;
            sh_reg    <= shift_amount;
            a_vld_reg <= rf_valid_reg[src_a_index];
            b_vld_reg <= rf_valid_reg[src_b_index];
        end
        if (cmd.exec)
        begin
            a_reg    <= a_cur;
            b_reg    <= b_cur;
            prod_reg <= prod_c;
        end
        if (ag_start)
        begin
            ea_reg <= a_cur + imm_reg;
        end
        if (ag_pipe_reg[0])
        begin
            qe_reg <= ea_prod[2*WORD_W-1:WORD_W];
        end
        if (ag_pipe_reg[1])
        begin
            rraw_reg <= ea_reg - q_times_d;
        end
        if (ag_pipe_reg[2])
        begin
            arem_reg <= (rraw_reg >= ADDR_DIV) ? rraw_reg - ADDR_DIV : rraw_reg;
        end
        if (cmd.commit)
        begin
            npc_out_reg   <= pc_next;
            wr_out_reg    <= wr;
            widx_out_reg  <= widx;
            wval_out_reg  <= wval;
            hi_out_reg    <= hi_next;
            lo_out_reg    <= lo_next;
            mw_out_reg    <= mw;
            maddr_out_reg <= maddr;
            dz_out_reg    <= dz;
            probe_out_reg <= a_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign next_pc        = npc_out_reg;
    assign reg_written    = wr_out_reg;
    assign written_index  = widx_out_reg;
    assign written_value  = wval_out_reg;
    assign hi_value       = hi_out_reg;
    assign lo_value       = lo_out_reg;
    assign mem_written    = mw_out_reg;
    assign mem_address    = maddr_out_reg;
    assign divide_by_zero = dz_out_reg;
    assign probe_value    = probe_out_reg;

endmodule
`default_nettype wire

/* rtl/mse_ctrl.sv */
// Controller state machine sequencing clear, execute, divide and commit.
`default_nettype none
module mse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mse_pkg::ctrl_sts_t sts,
    output mse_pkg::ctrl_cmd_t cmd
);
    import mse_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_EXEC;
            S_EXEC:  state_next = sts.needs_div ? S_DIV : S_DONE;
            S_DIV:   if (sts.div_done) state_next = S_DONE;
            S_DONE:  if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_CLEAR: cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.div_start = sts.needs_div;
            end
            S_DIV:   ;
            S_DONE:  cmd.commit = sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> $past(state_reg) == S_EXEC || $past(state_reg) == S_DIV)
        else $error("divide wait entered from wrong state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide wait");

    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == S_IDLE && !in_stall)
        else $error("no return to idle after commit");

endmodule
`default_nettype wire

/* rtl/mips_subset_execute_unit.sv */
// Top level of the MIPS subset execute unit: controller plus datapath.
//
//  channel | direction | handshake            | beat contents
//  --------+-----------+----------------------+----------------------------------------
//  in      | input     | in_valid / in_stall  | command, indexes, immediate, shift_amount
//  out     | output    | out_valid / out_stall| next_pc, write info, hi/lo, mem info, probe
//
// Sequence: ALU, shift, branch, jump and mult instructions go through accept,
// register file read and commit. div also waits for a 32-step restoring divider
// that works on magnitudes. lw and sw wait while the address is reduced modulo
// MEM_WORDS by a reciprocal multiply, a multiply-subtract and one correction step.
// Reset runs a clearing pass over all MEM_WORDS words of the data RAM with in_stall
// high. The result sits in an output register; a new beat is accepted while it
// waits, and the next commit waits for it.
`default_nettype none
module mips_subset_execute_unit #(
    parameter int MEM_WORDS = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [4:0]                         command,
    input  logic [mse_pkg::IDX_W-1:0]          dest_index,
    input  logic [mse_pkg::IDX_W-1:0]          src_a_index,
    input  logic [mse_pkg::IDX_W-1:0]          src_b_index,
    input  logic signed [mse_pkg::WORD_W-1:0]  immediate,
    input  logic [mse_pkg::IDX_W-1:0]          shift_amount,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mse_pkg::WORD_W-1:0]         next_pc,
    output logic                               reg_written,
    output logic [mse_pkg::IDX_W-1:0]          written_index,
    output logic signed [mse_pkg::WORD_W-1:0]  written_value,
    output logic signed [mse_pkg::WORD_W-1:0]  hi_value,
    output logic signed [mse_pkg::WORD_W-1:0]  lo_value,
    output logic                               mem_written,
    output logic [mse_pkg::MADDR_W-1:0]        mem_address,
    output logic                               divide_by_zero,
    output logic signed [mse_pkg::WORD_W-1:0]  probe_value
);
    import mse_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequencing: clear pass, accept, operand latch, divide/address wait, commit
    mse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // all architectural state and the result register live here
    mse_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .command        (command),
        .dest_index     (dest_index),
        .src_a_index    (src_a_index),
        .src_b_index    (src_b_index),
        .immediate      (immediate),
        .shift_amount   (shift_amount),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .next_pc        (next_pc),
        .reg_written    (reg_written),
        .written_index  (written_index),
        .written_value  (written_value),
        .hi_value       (hi_value),
        .lo_value       (lo_value),
        .mem_written    (mem_written),
        .mem_address    (mem_address),
        .divide_by_zero (divide_by_zero),
        .probe_value    (probe_value)
    );

endmodule
`default_nettype wire
